@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/arpc_pkg.sv @@
// Package with types and constants of the ARP cache engine.
package arpc_pkg;
    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_IP_IN  = 2'd1;
    localparam logic [1:0] KIND_ARP_IN = 2'd2;
    localparam logic [1:0] KIND_IP_OUT = 2'd3;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;
    localparam logic [1:0] ACT_SEND    = 2'd3;

    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    localparam logic [2:0] REG_HOST_IP  = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_ROUTER   = 3'd2;
    localparam logic [2:0] REG_OWN_MAC  = 3'd3;
    localparam logic [2:0] REG_MAX_AGE  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_PICK, ST_WRITE, ST_OUT
    } t_state;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_NOP, OP_SCAN, OP_AGE, OP_WRITE
    } t_cell_op;

    // Token that travels down the chain, one cell per cycle.
    typedef struct packed {
        logic             hit;       // matching in-use entry seen
        logic [IDX_W-1:0] hit_idx;
        logic [47:0]      hit_mac;
        logic             empty;     // unused entry seen
        logic [IDX_W-1:0] empty_idx;
        logic [7:0]       best_age;
        logic [IDX_W-1:0] best_idx;
    } t_token;

    // Command that the controller gives to all cells.
    typedef struct packed {
        t_cell_op         op;
        logic [31:0]      key;
        logic [47:0]      mac;
        logic [7:0]       clock;
        logic [7:0]       max_age;
        logic [IDX_W-1:0] wr_idx;
    } t_cell_cmd;
endpackage

@@ rtl/arp_cache_engine_core.sv @@
// Top level of the ARP cache engine: controller plus a chain of entry cells.
//
//  channel | direction | handshake           | payload
//  in      | sink      | i_valid / o_ready   | kind, peer_ip, peer_mac, opcode, target, short
//  out     | source    | o_valid / i_ready   | action, dest_mac, ask_ip
//  cfg     | sink      | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// A lookup or learn walks the token through the TABLE_ENTRIES cells, one cell per cycle,
// passing the states SCAN, PICK, WRITE and OUT; a tick passes WRITE and OUT.
// Items that neither look up nor learn go from IDLE straight to OUT.
// One item is worked on at a time; o_ready is high while the engine is idle.
// A stalled result holds in the output register and blocks the next item.
// Reset is synchronous and clears all entries and the age clock at once.
`include "assert_macros.svh"
module arp_cache_engine_core import arpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_peer_ip,
    input  logic [47:0] i_peer_mac,
    input  logic [15:0] i_arp_opcode,
    input  logic [31:0] i_arp_target_ip,
    input  logic        i_frame_short,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_action,
    output logic [47:0] o_dest_mac,
    output logic [31:0] o_ask_ip,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    logic [31:0] r_host_ip, r_mask, r_router;
    logic [47:0] r_own_mac;
    logic [7:0]  r_max_age, r_clock, n_clock;

    t_state      r_state, n_state;
    logic [1:0]  r_kind;
    logic [31:0] r_key, n_key;
    logic [47:0] r_mac;
    logic        r_learn, n_learn;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic        r_hit;
    logic [47:0] r_hit_mac;
    logic [1:0]  r_action, n_action;
    logic [47:0] r_dmac, n_dmac;
    logic [31:0] r_ask, n_ask;
    logic        r_ovalid, n_ovalid;
    t_cell_op    w_op;
    t_cell_cmd   w_cmd;
    t_token      w_tok [TABLE_ENTRIES+1];
    t_token      w_last;
    logic        w_in_acc;

    assign w_in_acc = i_valid && o_ready;
    assign o_ready  = (r_state == ST_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_ip <= '0;
            r_mask    <= '0;
            r_router  <= '0;
            r_own_mac <= '0;
            r_max_age <= 8'd120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HOST_IP: r_host_ip <= i_cfg_data[31:0];
                REG_MASK:    r_mask    <= i_cfg_data[31:0];
                REG_ROUTER:  r_router  <= i_cfg_data[31:0];
                REG_OWN_MAC: r_own_mac <= i_cfg_data;
                REG_MAX_AGE: r_max_age <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Broadcast command to the cells.
    always_comb begin
        w_op = OP_NOP;
        if (r_state == ST_SCAN) begin
            w_op = OP_SCAN;
        end else if (r_state == ST_WRITE && r_kind == KIND_TICK) begin
            w_op = OP_AGE;
        end else if (r_state == ST_WRITE && r_learn) begin
            w_op = OP_WRITE;
        end
        w_cmd.op      = w_op;
        w_cmd.key     = r_key;
        w_cmd.mac     = r_mac;
        w_cmd.clock   = r_clock;
        w_cmd.max_age = r_max_age;
        w_cmd.wr_idx  = r_wr_idx;
    end

    // Token entering the first cell: a fresh token at the start of a scan.
    assign w_tok[0] = '0;

    // The cell at position k works on the token while the scan counter equals k.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic w_act;
        assign w_act = (r_state == ST_SCAN) && (r_cnt == CNT_W'(g));
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_active(w_act),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end
    assign w_last = w_tok[TABLE_ENTRIES];

    // Control state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_clock  <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_learn  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clock  <= n_clock;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_learn  <= n_learn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_kind;
            r_mac  <= i_peer_mac;
        end
        r_key    <= n_key;
        r_wr_idx <= n_wr_idx;
        r_action <= n_action;
        r_dmac   <= n_dmac;
        r_ask    <= n_ask;
        if (r_state == ST_PICK) begin
            r_hit     <= w_last.hit;
            r_hit_mac <= w_last.hit_mac;
        end
    end

    // Next state and result.
    always_comb begin
        n_state  = r_state;
        n_clock  = r_clock;
        n_ovalid = r_ovalid;
        n_cnt    = r_cnt;
        n_learn  = r_learn;
        n_key    = r_key;
        n_wr_idx = r_wr_idx;
        n_action = r_action;
        n_dmac   = r_dmac;
        n_ask    = r_ask;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_cnt    = '0;
                    n_action = ACT_NONE;
                    n_dmac   = '0;
                    n_ask    = '0;
                    n_key    = i_peer_ip;
                    n_learn  = 1'b0;
                    unique case (i_kind)
                        KIND_TICK: begin
                            n_clock = r_clock + 8'd1;
                            n_state = ST_WRITE;
                        end
                        KIND_IP_IN: begin
                            n_learn = ((i_peer_ip & r_mask) == (r_host_ip & r_mask));
                            n_state = n_learn ? ST_SCAN : ST_OUT;
                        end
                        KIND_ARP_IN: begin
                            n_state = ST_OUT;
                            if (!i_frame_short && i_arp_target_ip == r_host_ip) begin
                                if (i_arp_opcode == OP_REQUEST) begin
                                    n_action = ACT_REPLY;
                                    n_dmac   = i_peer_mac;
                                    n_ask    = i_peer_ip;
                                end else if (i_arp_opcode == OP_REPLY) begin
                                    n_learn = 1'b1;
                                    n_state = ST_SCAN;
                                end
                            end
                        end
                        default: begin
                            if ((i_peer_ip & r_mask) != (r_host_ip & r_mask)) begin
                                n_key = r_router;
                            end
                            n_state = ST_SCAN;
                        end
                    endcase
                    n_ovalid = (n_state == ST_OUT);
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                // Token has left the last cell.
                if (w_last.hit) begin
                    n_wr_idx = w_last.hit_idx;
                end else if (w_last.empty) begin
                    n_wr_idx = w_last.empty_idx;
                end else begin
                    n_wr_idx = w_last.best_idx;
                end
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (r_kind == KIND_IP_OUT) begin
                    if (r_hit) begin
                        n_action = ACT_SEND;
                        n_dmac   = r_hit_mac;
                    end else begin
                        n_action = ACT_REQUEST;
                        n_dmac   = '1;
                        n_ask    = r_key;
                    end
                end
                n_ovalid = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid    = r_ovalid;
    assign o_action   = r_action;
    assign o_dest_mac = r_dmac;
    assign o_ask_ip   = r_ask;

    `ASSERT_IMP(a_out_state, i_clk, i_rst_n, o_valid, r_state == ST_OUT)
    `ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_valid && i_ready, o_ready && !o_valid)
    `ASSERT_IMP(a_req_bcast, i_clk, i_rst_n, o_valid && o_action == ACT_REQUEST,
        o_dest_mac == '1)
    `ASSERT_NXT(a_clock_tick, i_clk, i_rst_n, o_ready && i_valid && i_kind == KIND_TICK,
        r_clock == $past(r_clock) + 8'd1)
endmodule

@@ rtl/arpc_cell.sv @@
// One cache entry cell: holds an entry and updates the token passing by.
module arpc_cell import arpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_active,
    input  t_cell_cmd        i_cmd,
    input  t_token           i_tok,
    output t_token           o_tok
);
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [7:0]  r_stamp;
    logic [7:0]  w_age;
    t_token      n_tok;
    t_token      r_tok;

    assign w_age = i_cmd.clock - r_stamp;

    // Entry storage; only the address needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip <= '0;
        end else if (i_cmd.op == OP_AGE) begin
            if (r_ip != '0 && w_age >= i_cmd.max_age) begin
                r_ip <= '0;
            end
        end else if (i_cmd.op == OP_WRITE && i_cmd.wr_idx == i_idx) begin
            r_ip <= i_cmd.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE && i_cmd.wr_idx == i_idx) begin
            r_mac   <= i_cmd.mac;
            r_stamp <= i_cmd.clock;
        end
    end

    // Token update: first hit, first empty, oldest with ties to lowest.
    always_comb begin
        n_tok = i_tok;
        if (i_active) begin
            if (!i_tok.hit && r_ip != '0 && r_ip == i_cmd.key) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = i_idx;
                n_tok.hit_mac = r_mac;
            end
            if (!i_tok.empty && r_ip == '0) begin
                n_tok.empty     = 1'b1;
                n_tok.empty_idx = i_idx;
            end
            if (w_age > i_tok.best_age) begin
                n_tok.best_age = w_age;
                n_tok.best_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;
endmodule

@@ tb/sv/arp_cache_engine_core_tb.sv @@
// Self-checking testbench of the ARP cache engine: directed and random traffic checked against a predictor.
module arp_cache_engine_core_tb import arpc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Expected results and the address cache predictor that produces them.
    class arp_scoreboard;
        logic [31:0] host_ip, mask, router;
        logic [47:0] own_mac;
        logic [7:0]  max_age;
        logic [31:0] ent_ip [TABLE_ENTRIES];
        logic [47:0] ent_mac [TABLE_ENTRIES];
        logic [7:0]  ent_stamp [TABLE_ENTRIES];
        logic [7:0]  age_clk;
        logic [1:0]  exp_action [$];
        logic [47:0] exp_mac [$];
        logic [31:0] exp_ask [$];
        int          errors;

        function new();
            host_ip = 0;
            mask = 0;
            router = 0;
            own_mac = 0;
            max_age = 8'd120;
            age_clk = 0;
            errors = 0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                ent_ip[k] = 0;
                ent_mac[k] = 0;
                ent_stamp[k] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] data);
            case (idx)
                REG_HOST_IP: host_ip = data[31:0];
                REG_MASK: mask = data[31:0];
                REG_ROUTER: router = data[31:0];
                REG_OWN_MAC: own_mac = data;
                REG_MAX_AGE: max_age = data[7:0];
                default: ;
            endcase
        endfunction

        function bit local_net(logic [31:0] a);
            return (a & mask) == (host_ip & mask);
        endfunction

        // Refresh a match, else fill the first free entry, else evict the oldest.
        function void learn(logic [31:0] ip, logic [47:0] mac);
            int slot;
            logic [7:0] best, a;
            slot = -1;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (slot < 0 && ent_ip[k] != 0 && ent_ip[k] == ip) slot = k;
            end
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (slot < 0 && ent_ip[k] == 0) slot = k;
            end
            if (slot < 0) begin
                best = 0;
                slot = 0;
                for (int k = 0; k < TABLE_ENTRIES; k++) begin
                    a = age_clk - ent_stamp[k];
                    if (a > best) begin
                        best = a;
                        slot = k;
                    end
                end
            end
            ent_ip[slot] = ip;
            ent_mac[slot] = mac;
            ent_stamp[slot] = age_clk;
        endfunction

        // Note an accepted input transaction and queue its result.
        function void note_input(logic [1:0] kind, logic [31:0] pip, logic [47:0] pmac,
                                 logic [15:0] op, logic [31:0] tip, logic shrt);
            logic [1:0]  act;
            logic [47:0] dmac;
            logic [31:0] ask, want;
            logic [7:0]  a;
            bit hit;
            act = ACT_NONE;
            dmac = 0;
            ask = 0;
            case (kind)
                KIND_TICK: begin
                    age_clk = age_clk + 8'd1;
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        a = age_clk - ent_stamp[k];
                        if (ent_ip[k] != 0 && a >= max_age) ent_ip[k] = 0;
                    end
                end
                KIND_IP_IN: begin
                    if (local_net(pip)) learn(pip, pmac);
                end
                KIND_ARP_IN: begin
                    if (!shrt && tip == host_ip) begin
                        if (op == OP_REQUEST) begin
                            act = ACT_REPLY;
                            dmac = pmac;
                            ask = pip;
                        end else if (op == OP_REPLY) begin
                            learn(pip, pmac);
                        end
                    end
                end
                default: begin
                    want = local_net(pip) ? pip : router;
                    hit = 0;
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        if (!hit && ent_ip[k] != 0 && ent_ip[k] == want) begin
                            hit = 1;
                            dmac = ent_mac[k];
                        end
                    end
                    if (hit) begin
                        act = ACT_SEND;
                    end else begin
                        act = ACT_REQUEST;
                        dmac = '1;
                        ask = want;
                    end
                end
            endcase
            exp_action.push_back(act);
            exp_mac.push_back(dmac);
            exp_ask.push_back(ask);
        endfunction

        // Compare a result transaction with the oldest expectation.
        function void check_result(logic [1:0] act, logic [47:0] dmac, logic [31:0] ask);
            logic [1:0]  e_act;
            logic [47:0] e_mac;
            logic [31:0] e_ask;
            if (exp_action.size() == 0) begin
                $error("unexpected result: action %0d", act);
                errors++;
                return;
            end
            e_act = exp_action.pop_front();
            e_mac = exp_mac.pop_front();
            e_ask = exp_ask.pop_front();
            if (act !== e_act) begin
                $error("action: expected %0d, got %0d", e_act, act);
                errors++;
            end
            if (dmac !== e_mac) begin
                $error("dest_mac: expected %h, got %h", e_mac, dmac);
                errors++;
            end
            if (ask !== e_ask) begin
                $error("ask_ip: expected %h, got %h", e_ask, ask);
                errors++;
            end
        endfunction

        function int pending();
            return exp_action.size();
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_kind = 0;
    logic [31:0] i_peer_ip = 0;
    logic [47:0] i_peer_mac = 0;
    logic [15:0] i_arp_opcode = 0;
    logic [31:0] i_arp_target_ip = 0;
    logic        i_frame_short = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_action;
    logic [47:0] o_dest_mac;
    logic [31:0] o_ask_ip;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [47:0] i_cfg_data = 0;

    arp_scoreboard sb = new();
    bit quiet_phase = 0;
    int idle_cycles = 0;
    logic [31:0] ip_pool [8];

    arp_cache_engine_core DUT (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Result checking and the hang watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_action, o_dest_mac, o_ask_ip);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL arp_cache_engine_core");
            $finish;
        end
    end

    // Receiver with random stall bursts.
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            i_ready <= 1;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
            if (!quiet_phase && $urandom_range(0, 1)) begin
                i_ready <= 0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, data);
    endtask

    // Wait until every result is in, then let the engine settle.
    task automatic drain();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(negedge i_clk);
    endtask

    // Send one input transaction, holding it until accepted.
    task automatic send(logic [1:0] kind, logic [31:0] pip, logic [47:0] pmac,
                        logic [15:0] op, logic [31:0] tip, logic shrt);
        i_valid <= 1;
        i_kind <= kind;
        i_peer_ip <= pip;
        i_peer_mac <= pmac;
        i_arp_opcode <= op;
        i_arp_target_ip <= tip;
        i_frame_short <= shrt;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(kind, pip, pmac, op, tip, shrt);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            i_valid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_ip();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 0;
            default: return ip_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    // Random item, mostly well-formed traffic on a small set of addresses.
    task automatic random_item();
        logic [1:0]  kind;
        logic [15:0] op;
        logic [31:0] tip;
        logic [47:0] mac;
        kind = 2'($urandom_range(0, 3));
        mac = 48'({$urandom(), $urandom()});
        case ($urandom_range(0, 5))
            0: op = 16'($urandom());
            1, 2: op = OP_REQUEST;
            default: op = OP_REPLY;
        endcase
        tip = ($urandom_range(0, 4) == 0) ? $urandom() : sb.host_ip;
        send(kind, pick_ip(), mac, op, tip, $urandom_range(0, 7) == 0);
        sender_gap();
    endtask

    task automatic random_phase(int count, logic [7:0] age, logic [31:0] msk);
        logic [31:0] net;
        write_reg(REG_MAX_AGE, {40'd0, age});
        write_reg(REG_MASK, {16'd0, msk});
        net = $urandom();
        write_reg(REG_HOST_IP, {16'd0, net});
        write_reg(REG_ROUTER, {16'd0, (net & msk) | ($urandom() & ~msk)});
        write_reg(REG_OWN_MAC, 48'({$urandom(), $urandom()}));
        for (int k = 0; k < 8; k++) ip_pool[k] = (net & msk) | ($urandom_range(0, 15) & ~msk);
        ip_pool[0] = sb.router;
        repeat (count) random_item();
        i_valid <= 0;
        drain();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed items on the reset configuration, then with a local network.
        send(KIND_IP_OUT, 0, 0, 0, 0, 0);
        i_valid <= 0;
        drain();
        write_reg(REG_HOST_IP, 48'h0000_0A00_0001);
        write_reg(REG_MASK, 48'h0000_FFFF_FF00);
        write_reg(REG_ROUTER, 48'h0000_0A00_00FE);
        write_reg(REG_OWN_MAC, '1);
        write_reg(REG_MAX_AGE, 48'd1);
        send(KIND_IP_IN, 32'h0A00_0005, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        send(KIND_IP_OUT, 32'h0A00_0005, 0, 0, 0, 0);
        send(KIND_TICK, 0, 0, 0, 0, 0);
        send(KIND_IP_OUT, 32'h0A00_0005, 0, 0, 0, 0);
        send(KIND_IP_IN, 32'hC000_0001, 48'h1, 0, 0, 0);
        send(KIND_ARP_IN, 32'h0A00_0007, 48'h1234, OP_REQUEST, 32'h0A00_0001, 0);
        send(KIND_ARP_IN, 32'h0A00_0007, 48'h1234, OP_REQUEST, 32'h0A00_0001, 1);
        send(KIND_ARP_IN, 32'h0A00_0007, 48'h1234, OP_REQUEST, 32'h0A00_0002, 0);
        send(KIND_ARP_IN, 32'h0A00_0007, 48'h1234, 16'hFFFF, 32'h0A00_0001, 0);
        send(KIND_ARP_IN, 32'h0A00_00FE, 48'hABCD, OP_REPLY, 32'h0A00_0001, 0);
        send(KIND_IP_OUT, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send(KIND_IP_IN, 32'h0A00_00FE, 48'h0, 0, 0, 0);
        send(KIND_IP_OUT, 32'h0A00_00FE, 0, 0, 0, 0);
        send(KIND_IP_IN, 32'h0, 48'h55, 0, 0, 0);
        send(KIND_IP_OUT, 32'h0, 0, 0, 0, 0);
        // Learn more entries than the table holds, with a tick midway that ages out the earlier ones.
        for (int k = 0; k < TABLE_ENTRIES + 2; k++) begin
            send(KIND_IP_IN, 32'h0A00_0010 + k, 48'h100 + k, 0, 0, 0);
            if (k == 3) send(KIND_TICK, 0, 0, 0, 0, 0);
        end
        i_valid <= 0;
        drain();

        // Random phases over several ages and masks, each drained before the next; the last without stalls or gaps.
        random_phase(150, 8'd255, 32'hFFFF_FFF0);
        random_phase(150, 8'd1, 32'h0);
        random_phase(200, 8'd3, 32'hFFFF_FFF8);
        random_phase(200, 8'd0, 32'hFFFF_FFFF);
        random_phase(150, 8'd6, 32'hFFFF_FF00);
        quiet_phase = 1;
        random_phase(150, 8'd4, 32'hFFFF_FFF0);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS arp_cache_engine_core");
        else
            $display("FAIL arp_cache_engine_core");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arp_cache_engine_core.sv
tb/sv/arp_cache_engine_core_tb.sv
